>>> hdl/mgtv_pkg.sv
// mgtv_pkg: types, codes and constants shared by the maze grid text validator
// no dependencies; imported by the top level and mgtv_core, not by mgtv_pipe_reg
`timescale 1ns / 1ps

package mgtv_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;
  localparam int unsigned OUT_COORD_W    = 11;
  localparam int unsigned HALF_W         = 10;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CHAR_W         = 8;

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ENTRY   = 8'h50;  // 'P'
  localparam logic [CHAR_W-1:0] CHAR_EXIT    = 8'h4B;  // 'K'
  localparam logic [CHAR_W-1:0] CHAR_WALL    = 8'h58;  // 'X'

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd1;

  localparam logic [HALF_W-1:0] HALF_RESET = 10'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_DUP_ENTRY = 3'd2,
    ST_DUP_EXIT  = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_IGNORED   = 3'd5
  } status_e;

  // fields listed from the highest bit down
  typedef struct packed {
    logic                   map_done;
    logic [OUT_COORD_W-1:0] exit_row;
    logic [OUT_COORD_W-1:0] exit_col;
    logic                   exit_found;
    logic [OUT_COORD_W-1:0] entrance_row;
    logic [OUT_COORD_W-1:0] entrance_col;
    logic                   entrance_found;
    logic [OUT_COORD_W-1:0] cell_col;
    logic [OUT_COORD_W-1:0] cell_row;
    logic                   cell_valid;
    status_e                status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

>>> hdl/maze_grid_text_validator.sv
// maze_grid_text_validator: top level, config registers, input and result stages
// depends on mgtv_pkg, mgtv_pipe_reg and mgtv_core
//
//   channel  | dir | handshake                    | payload
//   ---------+-----+------------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata char_code, tuser restart
//   m_axis   | out | m_axis_tvalid / m_axis_tready | tdata result fields, tlast map_done
//   cfg      | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while m_axis does not stall; an accepted item
// passes through the input register, then the combinational check into the
// result register, and its result is offered from there
// counters and marker state update when an item moves into the result register
// a stalled m_axis holds the result register and then the input register
// reset clears counters, markers and latches and sets both half sizes to 1
`timescale 1ns / 1ps

module maze_grid_text_validator #(
  parameter int unsigned COORD_BITS = mgtv_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mgtv_pkg::CHAR_W-1:0]      s_axis_tdata,  // char_code
  input  logic                             s_axis_tuser,  // restart
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, cell_valid, cell_row, cell_col, entrance_found, entrance_col,
  // entrance_row, exit_found, exit_col, exit_row
  output logic [71:0]                      m_axis_tdata,
  output logic                             m_axis_tlast,  // map_done
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mgtv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mgtv_pkg::HALF_W-1:0]      cfg_data_i
);

  import mgtv_pkg::*;

  localparam int unsigned IN_W = CHAR_W + 1;

  logic [HALF_W-1:0] half_width_q, half_height_q;
  logic              in_valid, out_ready;
  logic [IN_W-1:0]   in_data;
  result_t           core_res, out_res;
  logic [RESULT_W-1:0] out_bits;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= HALF_RESET;
      half_height_q <= HALF_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_HALF_WIDTH) begin
        half_width_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_HALF_HEIGHT) begin
        half_height_q <= cfg_data_i;
      end
    end
  end

  mgtv_pipe_reg #(
    .WIDTH(IN_W)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  ({s_axis_tuser, s_axis_tdata}),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .data_o  (in_data)
  );

  mgtv_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_valid && out_ready),
    .restart_i     (in_data[IN_W-1]),
    .char_i        (in_data[CHAR_W-1:0]),
    .half_width_i  (half_width_q),
    .half_height_i (half_height_q),
    .result_o      (core_res)
  );

  mgtv_pipe_reg #(
    .WIDTH(RESULT_W)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (core_res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_bits)
  );

  assign out_res = result_t'(out_bits);

  assign m_axis_tdata = {out_res.exit_row, out_res.exit_col, out_res.exit_found,
                         out_res.entrance_row, out_res.entrance_col,
                         out_res.entrance_found, out_res.cell_col, out_res.cell_row,
                         out_res.cell_valid, out_res.status};
  assign m_axis_tlast = out_res.map_done;

  a_cell_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && out_res.cell_valid |-> out_res.status == ST_OK && !out_res.map_done)
    else $error("cell reported with a failing status");

  a_done_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && out_res.map_done |-> out_res.status == ST_OK)
    else $error("map done raised with a failing status");

  a_ignored_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && out_res.status == ST_IGNORED |->
          !out_res.cell_valid && !out_res.map_done)
    else $error("ignored item reports a cell or done");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
      !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register is empty");

  a_done_latches : assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid && out_ready && core_res.map_done ##1 in_valid && out_ready &&
          !in_data[IN_W-1] |-> core_res.status == ST_IGNORED)
    else $error("item after map done not ignored");

endmodule

>>> hdl/mgtv_pipe_reg.sv
// mgtv_pipe_reg: one-entry valid/ready register stage of generic width
// depends on nothing; used for the input and the result register
`timescale 1ns / 1ps

module mgtv_pipe_reg #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

>>> hdl/mgtv_core.sv
// mgtv_core: row/column counters, marker tracking and the per-byte cell check
// depends on mgtv_pkg; fed from the input register, feeds the result register
`timescale 1ns / 1ps

module mgtv_core #(
  parameter int unsigned COORD_BITS = mgtv_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          restart_i,
  input  logic [mgtv_pkg::CHAR_W-1:0]   char_i,
  input  logic [mgtv_pkg::HALF_W-1:0]   half_width_i,
  input  logic [mgtv_pkg::HALF_W-1:0]   half_height_i,
  output mgtv_pkg::result_t             result_o
);

  import mgtv_pkg::*;

  localparam int unsigned CMP_W =
      ((COORD_BITS > OUT_COORD_W) ? COORD_BITS : OUT_COORD_W) + 1;

  logic [COORD_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [COORD_BITS-1:0] ent_r_q, ent_r_d, ent_c_q, ent_c_d;
  logic [COORD_BITS-1:0] ext_r_q, ext_r_d, ext_c_q, ext_c_d;
  logic                  ent_seen_q, ent_seen_d, ext_seen_q, ext_seen_d;
  logic                  err_q, err_d, done_q, done_d;

  logic [COORD_BITS-1:0] r_cur, c_cur;
  logic [CMP_W-1:0]      r_w, c_w, width_w, last_w;
  logic [CMP_W-1:0]      ent_r_w, ent_c_w, ext_r_w, ext_c_w;
  logic                  border;
  status_e               status;
  logic                  cell_ok, map_done;

  always_comb begin
    r_cur      = restart_i ? '0 : row_q;
    c_cur      = restart_i ? '0 : col_q;
    ent_seen_d = restart_i ? 1'b0 : ent_seen_q;
    ent_r_d    = restart_i ? '0 : ent_r_q;
    ent_c_d    = restart_i ? '0 : ent_c_q;
    ext_seen_d = restart_i ? 1'b0 : ext_seen_q;
    ext_r_d    = restart_i ? '0 : ext_r_q;
    ext_c_d    = restart_i ? '0 : ext_c_q;
    err_d      = restart_i ? 1'b0 : err_q;
    done_d     = restart_i ? 1'b0 : done_q;
    row_d      = r_cur;
    col_d      = c_cur;

    r_w     = CMP_W'(r_cur);
    c_w     = CMP_W'(c_cur);
    width_w = CMP_W'({half_width_i, 1'b1});
    last_w  = CMP_W'({half_height_i, 1'b0});
    border  = (r_w == '0) || (r_w == last_w) || (c_w == '0) ||
              (c_w == width_w - CMP_W'(1));

    status   = ST_OK;
    map_done = 1'b0;

    if (err_d || done_d) begin
      status = ST_IGNORED;
    end else if (c_w < width_w) begin
      priority if (char_i == CHAR_NUL || char_i == CHAR_NEWLINE) begin
        status = ST_BAD_LEN;
      end else if (char_i == CHAR_WALL) begin
        status = ST_OK;
      end else if (!border) begin
        status = (char_i == CHAR_SPACE) ? ST_OK : ST_BAD_CHAR;
      end else if (char_i == CHAR_ENTRY) begin
        if (ent_seen_d) begin
          status = ST_DUP_ENTRY;
        end else begin
          ent_seen_d = 1'b1;
          ent_r_d    = r_cur;
          ent_c_d    = c_cur;
        end
      end else if (char_i == CHAR_EXIT) begin
        if (ext_seen_d) begin
          status = ST_DUP_EXIT;
        end else begin
          ext_seen_d = 1'b1;
          ext_r_d    = r_cur;
          ext_c_d    = c_cur;
        end
      end else begin
        status = ST_BAD_CHAR;
      end
      if (status == ST_OK) begin
        col_d = c_cur + COORD_BITS'(1);
      end
    end else if (char_i != CHAR_NEWLINE) begin
      status = ST_BAD_LEN;
    end else begin
      col_d = '0;
      if (r_w == last_w) begin
        map_done = 1'b1;
        done_d   = 1'b1;
      end else begin
        row_d = r_cur + COORD_BITS'(1);
      end
    end

    cell_ok = (status == ST_OK) && (c_w < width_w) && !map_done;
    if (status != ST_OK && status != ST_IGNORED) begin
      err_d = 1'b1;
    end

    ent_r_w = CMP_W'(ent_r_d);
    ent_c_w = CMP_W'(ent_c_d);
    ext_r_w = CMP_W'(ext_r_d);
    ext_c_w = CMP_W'(ext_c_d);
  end

  // cell_ok only ever rises together with an ok status on a cell byte
  always_comb begin
    result_o.status         = status;
    result_o.cell_valid     = cell_ok;
    result_o.cell_row       = r_w[OUT_COORD_W-1:0];
    result_o.cell_col       = c_w[OUT_COORD_W-1:0];
    result_o.map_done       = map_done;
    result_o.entrance_found = ent_seen_d;
    result_o.entrance_col   = ent_c_w[OUT_COORD_W-1:0];
    result_o.entrance_row   = ent_r_w[OUT_COORD_W-1:0];
    result_o.exit_found     = ext_seen_d;
    result_o.exit_col       = ext_c_w[OUT_COORD_W-1:0];
    result_o.exit_row       = ext_r_w[OUT_COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      ent_seen_q <= 1'b0;
      ent_r_q    <= '0;
      ent_c_q    <= '0;
      ext_seen_q <= 1'b0;
      ext_r_q    <= '0;
      ext_c_q    <= '0;
      err_q      <= 1'b0;
      done_q     <= 1'b0;
    end else if (step_i) begin
      row_q      <= row_d;
      col_q      <= col_d;
      ent_seen_q <= ent_seen_d;
      ent_r_q    <= ent_r_d;
      ent_c_q    <= ent_c_d;
      ext_seen_q <= ext_seen_d;
      ext_r_q    <= ext_r_d;
      ext_c_q    <= ext_c_d;
      err_q      <= err_d;
      done_q     <= done_d;
    end
  end

endmodule

>>> tb/sv/maze_grid_text_validator_test.sv
// maze_grid_text_validator_test: self-checking bench for the maze text validator
// drives byte items and size registers, predicts every report, compares field by field
// depends on mgtv_pkg and maze_grid_text_validator
`timescale 1ns / 1ps

module maze_grid_text_validator_test;
  import mgtv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    bit              rs;
    logic [CHAR_W-1:0] ch;
    bit              pinned;
    status_e         st;
  } dir_row_t;

  typedef struct packed {
    logic [HALF_W-1:0] hw;
    logic [HALF_W-1:0] hh;
    int unsigned       quota;
  } phase_t;

  // reset sizes are 3x3; pinned rows carry the status that must come back
  localparam dir_row_t DIRECTED [0:24] = '{
    '{1'b0, CHAR_WALL,    1'b1, ST_OK},
    '{1'b0, CHAR_ENTRY,   1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_NEWLINE, 1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_SPACE,   1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_NEWLINE, 1'b0, ST_OK},
    '{1'b0, CHAR_EXIT,    1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_NEWLINE, 1'b0, ST_OK},
    '{1'b0, 8'hFF,        1'b1, ST_IGNORED},
    '{1'b1, CHAR_ENTRY,   1'b0, ST_OK},
    '{1'b0, CHAR_ENTRY,   1'b1, ST_DUP_ENTRY},
    '{1'b1, CHAR_EXIT,    1'b0, ST_OK},
    '{1'b0, CHAR_EXIT,    1'b1, ST_DUP_EXIT},
    '{1'b1, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_NEWLINE, 1'b1, ST_BAD_LEN},
    '{1'b1, CHAR_NUL,     1'b1, ST_BAD_LEN},
    '{1'b1, 8'hFF,        1'b1, ST_BAD_CHAR},
    '{1'b1, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b0, ST_OK},
    '{1'b0, CHAR_WALL,    1'b1, ST_BAD_LEN}
  };

  localparam phase_t PHASES [0:8] = '{
    '{10'd1,    10'd1,    250},
    '{10'd0,    10'd0,    120},
    '{10'd2,    10'd3,    300},
    '{10'd1023, 10'd1023, 1},
    '{10'd3,    10'd2,    250},
    '{10'd0,    10'd6,    150},
    '{10'd1023, 10'd0,    1},
    '{10'd7,    10'd0,    150},
    '{10'd4,    10'd4,    250}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CHAR_W-1:0]      s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [71:0]            m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_HALF_WIDTH;
  logic [HALF_W-1:0]      cfg_data_i = '0;

  // predictor state
  logic [HALF_W-1:0]      size_w = HALF_RESET;
  logic [HALF_W-1:0]      size_h = HALF_RESET;
  logic [OUT_COORD_W-1:0] cur_row = '0;
  logic [OUT_COORD_W-1:0] cur_col = '0;
  bit                     have_entry = 1'b0;
  bit                     have_exit = 1'b0;
  logic [OUT_COORD_W-1:0] entry_r = '0, entry_c = '0;
  logic [OUT_COORD_W-1:0] exit_r = '0, exit_c = '0;
  bit                     rejected = 1'b0;
  bit                     finished = 1'b0;

  result_t     predicted_reports[$];
  result_t     sink_got;
  int unsigned fail_count = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned live_bytes = 0;
  int unsigned reject_count = 0;
  int unsigned reports_seen = 0;
  int unsigned mazes_done = 0;
  int unsigned sink_gap = 0;
  bit          sink_calm = 1'b0;
  bit          src_calm = 1'b0;

  maze_grid_text_validator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles,
               predicted_reports.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("st=%0d v=%0d at(%0d,%0d) done=%0d P=%0d(%0d,%0d) K=%0d(%0d,%0d)",
                     r.status, r.cell_valid, r.cell_row, r.cell_col, r.map_done,
                     r.entrance_found, r.entrance_row, r.entrance_col,
                     r.exit_found, r.exit_row, r.exit_col);
  endfunction

  function automatic void compare_report(result_t e, result_t g);
    string bad;
    bad = "";
    if (e.status !== g.status) bad = {bad, " status"};
    if (e.cell_valid !== g.cell_valid) bad = {bad, " cell_valid"};
    if (e.cell_row !== g.cell_row) bad = {bad, " cell_row"};
    if (e.cell_col !== g.cell_col) bad = {bad, " cell_col"};
    if (e.map_done !== g.map_done) bad = {bad, " map_done"};
    if (e.entrance_found !== g.entrance_found) bad = {bad, " entrance_found"};
    if (e.entrance_col !== g.entrance_col) bad = {bad, " entrance_col"};
    if (e.entrance_row !== g.entrance_row) bad = {bad, " entrance_row"};
    if (e.exit_found !== g.exit_found) bad = {bad, " exit_found"};
    if (e.exit_col !== g.exit_col) bad = {bad, " exit_col"};
    if (e.exit_row !== g.exit_row) bad = {bad, " exit_row"};
    if (bad != "") begin
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
        $display("report %0d mismatch in%s", reports_seen, bad);
        $display("  expected %s", describe(e));
        $display("  actual   %s", describe(g));
      end
    end
  endfunction

  // one byte through the validator: status, position and marker tracking
  function automatic result_t judge_byte(bit rs, logic [CHAR_W-1:0] ch);
    result_t     res;
    status_e     st;
    int unsigned width, last_row;
    bit          border;
    width = 2 * size_w + 1;
    last_row = 2 * size_h;
    if (rs) begin
      cur_row = '0;
      cur_col = '0;
      have_entry = 1'b0;
      have_exit = 1'b0;
      entry_r = '0;
      entry_c = '0;
      exit_r = '0;
      exit_c = '0;
      rejected = 1'b0;
      finished = 1'b0;
    end
    res = '0;
    res.cell_row = cur_row;
    res.cell_col = cur_col;
    st = ST_OK;
    if (rejected || finished) begin
      st = ST_IGNORED;
    end else if (cur_col < width) begin
      border = (cur_row == 0) || (cur_row == last_row) || (cur_col == 0) ||
               (cur_col == width - 1);
      if (ch == CHAR_NUL || ch == CHAR_NEWLINE) begin
        st = ST_BAD_LEN;
      end else if (ch == CHAR_WALL) begin
        st = ST_OK;
      end else if (!border) begin
        st = (ch == CHAR_SPACE) ? ST_OK : ST_BAD_CHAR;
      end else if (ch == CHAR_ENTRY) begin
        if (have_entry) begin
          st = ST_DUP_ENTRY;
        end else begin
          have_entry = 1'b1;
          entry_r = cur_row;
          entry_c = cur_col;
        end
      end else if (ch == CHAR_EXIT) begin
        if (have_exit) begin
          st = ST_DUP_EXIT;
        end else begin
          have_exit = 1'b1;
          exit_r = cur_row;
          exit_c = cur_col;
        end
      end else begin
        st = ST_BAD_CHAR;
      end
      if (st == ST_OK) begin
        res.cell_valid = 1'b1;
        cur_col = cur_col + 1'b1;
      end
    end else if (ch != CHAR_NEWLINE) begin
      st = ST_BAD_LEN;
    end else begin
      cur_col = '0;
      if (cur_row == last_row) begin
        res.map_done = 1'b1;
        finished = 1'b1;
      end else begin
        cur_row = cur_row + 1'b1;
      end
    end
    if (st != ST_OK && st != ST_IGNORED) rejected = 1'b1;
    res.status = st;
    res.entrance_found = have_entry;
    res.entrance_col = entry_c;
    res.entrance_row = entry_r;
    res.exit_found = have_exit;
    res.exit_col = exit_c;
    res.exit_row = exit_r;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sink_got = result_t'({m_axis_tlast, m_axis_tdata});
        reports_seen++;
        if (sink_got.map_done) mazes_done++;
        if (predicted_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected report %s", describe(sink_got));
        end else begin
          compare_report(predicted_reports.pop_front(), sink_got);
        end
        if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
        sink_gap = draw_gap(sink_calm);
      end else if (sink_gap != 0) begin
        sink_gap--;
      end
      m_axis_tready <= (sink_gap == 0);
    end
  end

  task automatic push_byte(bit rs, logic [CHAR_W-1:0] ch, bit pinned, status_e pin_st);
    int unsigned gap;
    result_t     res;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = draw_gap(src_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tuser <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
    res = judge_byte(rs, ch);
    if (pinned) res.status = pin_st;
    bytes_sent++;
    if (res.status != ST_IGNORED) live_bytes++;
    if (res.status != ST_OK && res.status != ST_IGNORED) reject_count++;
    predicted_reports.push_back(res);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_HALF_WIDTH) size_w = val;
    else if (idx == CFG_HALF_HEIGHT) size_h = val;
  endtask

  // mostly well-formed mazes with random walls and markers; some carry one fault
  task automatic run_map(int unsigned hw, int unsigned hh);
    int unsigned width, total, bad_at, last_idx, entry_at, exit_at, idx, r, c;
    logic [CHAR_W-1:0] ch;
    width = 2 * hw + 1;
    total = (width + 1) * (2 * hh + 1);
    if (total > 256 || $urandom_range(0, 99) < 35)
      bad_at = $urandom_range(0, (total > 256) ? 255 : total - 1);
    else
      bad_at = total;
    last_idx = (bad_at == total) ? total - 1 : bad_at + $urandom_range(0, 3);
    if (last_idx > total - 1) last_idx = total - 1;
    entry_at = $urandom_range(0, (total > 256) ? 255 : total - 1);
    exit_at = $urandom_range(0, (total > 256) ? 255 : total - 1);
    for (idx = 0; idx <= last_idx; idx++) begin
      r = idx / (width + 1);
      c = idx % (width + 1);
      if (c == width)
        ch = CHAR_NEWLINE;
      else if (r == 0 || r == 2 * hh || c == 0 || c == width - 1)
        ch = (idx == entry_at) ? CHAR_ENTRY : (idx == exit_at) ? CHAR_EXIT : CHAR_WALL;
      else
        ch = $urandom_range(0, 1) ? CHAR_WALL : CHAR_SPACE;
      if (idx == bad_at) begin
        case ($urandom_range(0, 5))
          0: ch = CHAR_W'($urandom_range(0, 255));
          1: ch = CHAR_NUL;
          2: ch = CHAR_NEWLINE;
          3: ch = CHAR_ENTRY;
          4: ch = CHAR_EXIT;
          default: ch = (c == width) ? CHAR_WALL : CHAR_SPACE;
        endcase
      end
      push_byte(idx == 0, ch, 1'b0, ST_OK);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3))
        push_byte(1'b0, CHAR_W'($urandom_range(0, 255)), 1'b0, ST_OK);
    end
  endtask

  initial begin
    int unsigned start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      push_byte(DIRECTED[i].rs, DIRECTED[i].ch, DIRECTED[i].pinned, DIRECTED[i].st);
    drain();

    foreach (PHASES[p]) begin
      write_size(CFG_HALF_WIDTH, PHASES[p].hw);
      write_size(CFG_HALF_HEIGHT, PHASES[p].hh);
      start = live_bytes;
      while (live_bytes - start < PHASES[p].quota) run_map(PHASES[p].hw, PHASES[p].hh);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (predicted_reports.size() != 0) fail_count++;
    $display("sent %0d bytes over %0d size settings, %0d reports checked", bytes_sent,
             $size(PHASES) + 1, reports_seen);
    $display("%0d mazes completed, %0d bytes rejected, %0d mismatches", mazes_done,
             reject_count, fail_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/mgtv_pkg.sv
hdl/mgtv_pipe_reg.sv
hdl/mgtv_core.sv
hdl/maze_grid_text_validator.sv
tb/sv/maze_grid_text_validator_test.sv
